// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL files that carry checks (the top level).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/orle_pkg.sv =====
// Types and constants of the ordered ring list engine.
`timescale 1ns / 1ps
`default_nettype none
package orle_pkg;

    localparam int KIND_W = 3;
    localparam int VAL_W  = 32;
    localparam int IDX_W  = 5;
    localparam int CNT_W  = 5;
    localparam int ELEM_W = 32;

    localparam logic [KIND_W-1:0] KIND_APPEND  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GET     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ROTATE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READALL = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd5;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_MOD,
        S_READ,
        S_CAP,
        S_SEARCH,
        S_SHIFT,
        S_ROTRD,
        S_ROTWR,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [ELEM_W-1:0] element;
        t_status           status;
        logic              last;
    } t_res;

endpackage
`default_nettype wire

// ===== sv/orle_in_if.sv =====
// Request channel: operation kind, value and index.
`timescale 1ns / 1ps
`default_nettype none
interface orle_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        kind;
    logic [31:0]       value;
    logic signed [4:0] index;

    modport source (output valid, output kind, output value, output index, input ready);
    modport sink (input valid, input kind, input value, input index, output ready);
endinterface
`default_nettype wire

// ===== sv/orle_out_if.sv =====
// Result channel: element, status, count and last mark.
`timescale 1ns / 1ps
`default_nettype none
interface orle_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] element;
    logic [1:0]  status;
    logic [4:0]  count;
    logic        last;

    modport source (output valid, output element, output status, output count,
                    output last, input ready);
    modport sink (input valid, input element, input status, input count,
                  input last, output ready);
endinterface
`default_nettype wire

// ===== sv/ordered_ring_list_engine.sv =====
// Top level of the ordered ring list engine: core plus output register.
// Usage:
// - i_in carries one operation (kind, value, index); it transfers when valid and
//   ready are both high. ready is high only while the engine is idle.
// - o_out carries results (element, status, count, last). Every operation gives
//   one result, except read all on a non-empty list, which gives one per element
//   from the head, the final one marked by last.
// - Steps: append, clear, unused kinds and the refusals on an empty or full list
//   finish in the execute step; rotate reads the head and writes it to the tail;
//   get reduces the index modulo the length by repeated subtraction, then reads;
//   delete searches from the head and, on a match past the head, moves each later
//   element up; read all reads and emits each element in turn. The final result
//   reaches o_out in the same cycle that the engine is ready again. These steps
//   come from the entry RAM (registered read) and the subtract unit.
// - A result sits in an output register, so the core can go back to idle and
//   take the next operation while the receiver stalls; a second result then
//   waits in the core until the register drains.
// - Reset (i_rst_n low at a clock edge) empties the list and sets the head to
//   slot zero; entry contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ordered_ring_list_engine #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    orle_in_if.sink   i_in,
    orle_out_if.source o_out
);
    import orle_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic              w_res_valid;
    logic              w_res_ready;
    t_res              w_res;
    logic [CW-1:0]     w_count;

    logic              r_oval;
    logic [ELEM_W-1:0] r_oelem;
    t_status           r_ostatus;
    logic [CNT_W-1:0]  r_ocount;
    logic              r_olast;

    orle_core #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready),
        .o_count     (w_count)
    );

    assign w_res_ready = !r_oval || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_oval <= 1'b1;
        end else if (o_out.ready) begin
            r_oval <= 1'b0;
        end
        if (w_res_valid && w_res_ready) begin
            r_oelem   <= w_res.element;
            r_ostatus <= w_res.status;
            r_ocount  <= CNT_W'(w_count);
            r_olast   <= w_res.last;
        end
    end

    assign o_out.valid   = r_oval;
    assign o_out.element = r_oelem;
    assign o_out.status  = r_ostatus;
    assign o_out.count   = r_ocount;
    assign o_out.last    = r_olast;

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    `ASSERT_SAME(a_empty_has_no_count, i_clk, i_rst_n, w_res_valid && w_res.status == ST_EMPTY, w_count == '0)
    `ASSERT_SAME(a_full_at_capacity, i_clk, i_rst_n, w_res_valid && w_res.status == ST_FULL, w_count == CW'(CAPACITY))
    `ASSERT_SAME(a_error_has_no_element, i_clk, i_rst_n, w_res_valid && w_res.status != ST_OK, w_res.element == '0)
endmodule
`default_nettype wire

// ===== sv/orle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module orle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule
`default_nettype wire

// ===== sv/orle_alu.sv =====
// Subtract/compare unit used for the index modulo reduction.
`timescale 1ns / 1ps
`default_nettype none
module orle_alu #(
    parameter int W = 5
) (
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    output logic [W-1:0]      o_diff,
    output logic              o_ge
);
    logic [W:0] w_sub;

    // borrow out of the extended subtract gives the compare
    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_sub[W-1:0];
    assign o_ge   = ~w_sub[W];
endmodule
`default_nettype wire

// ===== sv/orle_core.sv =====
// Sequencer and datapath: list state, entry RAM and operation steps.
`timescale 1ns / 1ps
`default_nettype none
module orle_core #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    orle_in_if.sink                           i_in,
    output logic                              o_res_valid,
    output orle_pkg::t_res                    o_res,
    input  wire logic                         i_res_ready,
    output logic [$clog2(CAPACITY+1)-1:0]     o_count
);
    import orle_pkg::*;

    localparam int HW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int GW = (CW > 4) ? CW : 4;
    localparam int SW = ((CW > IDX_W) ? CW : IDX_W) + 1;

    t_state                r_state, n_state;
    logic [HW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_ptr, n_ptr;
    logic [CW-1:0]         r_cptr, n_cptr;
    logic                  r_pend, n_pend;
    logic [GW-1:0]         r_goal, n_goal;
    logic [KIND_W-1:0]     r_kind, n_kind;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [ELEM_W-1:0]     r_elem, n_elem;
    t_status               r_status, n_status;
    logic                  r_last, n_last;

    logic                  w_we;
    logic [HW-1:0]         w_waddr;
    logic [VALUE_BITS-1:0] w_wdata;
    logic [HW-1:0]         w_raddr;
    logic [VALUE_BITS-1:0] w_rdata;
    logic [GW-1:0]         w_diff;
    logic                  w_ge;
    logic [SW-1:0]         w_sum;
    logic [CW:0]           w_ptr_inc;

    // physical slot of a logical position counted from the head
    function automatic logic [HW-1:0] f_slot(input logic [HW-1:0] head,
                                             input logic [CW-1:0] pos);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(pos);
        if (sum >= (CW+1)'(CAPACITY)) begin
            sum = sum - (CW+1)'(CAPACITY);
        end
        return sum[HW-1:0];
    endfunction

    orle_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    orle_alu #(
        .W (GW)
    ) u_alu (
        .i_a    (r_goal),
        .i_b    (GW'(r_count)),
        .o_diff (w_diff),
        .o_ge   (w_ge)
    );

    assign w_sum = {{(SW-IDX_W){r_idx[IDX_W-1]}}, r_idx} + SW'(r_count);
    assign w_ptr_inc = {1'b0, r_ptr} + (CW+1)'(1);

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_EMIT);
    assign o_res       = '{element: r_elem, status: r_status, last: r_last};
    assign o_count     = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_ptr    <= n_ptr;
        r_cptr   <= n_cptr;
        r_goal   <= n_goal;
        r_kind   <= n_kind;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_elem   <= n_elem;
        r_status <= n_status;
        r_last   <= n_last;
    end

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_cptr   = r_cptr;
        n_pend   = r_pend;
        n_goal   = r_goal;
        n_kind   = r_kind;
        n_val    = r_val;
        n_idx    = r_idx;
        n_elem   = r_elem;
        n_status = r_status;
        n_last   = r_last;
        w_we     = 1'b0;
        w_waddr  = '0;
        w_wdata  = r_val;
        w_raddr  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_kind  = i_in.kind;
                    n_val   = VALUE_BITS'(i_in.value);
                    n_idx   = i_in.index;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                // append, clear, unused kinds and refusals finish here with a single status-only result
                n_elem   = '0;
                n_last   = 1'b1;
                n_status = ST_OK;
                n_state  = S_EMIT;
                n_ptr    = '0;
                n_pend   = 1'b0;
                unique case (r_kind)
                    KIND_APPEND: begin
                        if (r_count >= CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = f_slot(r_head, r_count);
                            n_count = r_count + CW'(1);
                        end
                    end
                    KIND_GET: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            if (r_idx[IDX_W-1]) begin
                                n_goal = w_sum[SW-1] ? '0 : w_sum[GW-1:0];
                            end else begin
                                n_goal = GW'(r_idx[IDX_W-2:0]);
                            end
                            n_state = S_MOD;
                        end
                    end
                    KIND_DELETE: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_state = S_SEARCH;
                        end
                    end
                    KIND_ROTATE: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_state = S_ROTRD;
                        end
                    end
                    KIND_READALL: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_state = S_READ;
                        end
                    end
                    KIND_CLEAR: begin
                        n_count = '0;
                        n_head  = '0;
                    end
                    default: begin
                    end
                endcase
            end

            S_MOD: begin
                if (w_ge) begin
                    n_goal = w_diff;
                end else begin
                    n_ptr   = r_goal[CW-1:0];
                    n_state = S_READ;
                end
            end

            S_READ: begin
                w_raddr  = f_slot(r_head, r_ptr);
                n_status = ST_OK;
                n_last   = (r_kind == KIND_GET) || (w_ptr_inc == (CW+1)'(r_count));
                n_state  = S_CAP;
            end

            S_CAP: begin
                n_elem  = ELEM_W'(w_rdata);
                n_state = S_EMIT;
            end

            S_SEARCH: begin
                // one read issued per cycle; compare uses the registered read of the address held in r_cptr
                w_raddr = f_slot(r_head, r_ptr);
                n_cptr  = r_ptr;
                n_pend  = (r_ptr < r_count);
                if (r_ptr < r_count) begin
                    n_ptr = r_ptr + CW'(1);
                end
                if (r_pend) begin
                    if (w_rdata == r_val) begin
                        n_elem   = '0;
                        n_last   = 1'b1;
                        n_status = ST_OK;
                        n_pend   = 1'b0;
                        if (r_cptr == '0) begin
                            n_count = r_count - CW'(1);
                            n_head  = (r_count == CW'(1)) ? '0 : f_slot(r_head, CW'(1));
                            n_state = S_EMIT;
                        end else begin
                            n_ptr   = r_cptr;
                            n_state = S_SHIFT;
                        end
                    end else if (({1'b0, r_cptr} + (CW+1)'(1)) == (CW+1)'(r_count)) begin
                        n_elem   = '0;
                        n_last   = 1'b1;
                        n_status = ST_NOTFOUND;
                        n_pend   = 1'b0;
                        n_state  = S_EMIT;
                    end
                end
            end

            S_SHIFT: begin
                // close the gap: read position p+1 while writing the previous read to p
                if (r_pend) begin
                    w_we    = 1'b1;
                    w_waddr = f_slot(r_head, r_cptr);
                    w_wdata = w_rdata;
                end
                if (w_ptr_inc < (CW+1)'(r_count)) begin
                    w_raddr = f_slot(r_head, w_ptr_inc[CW-1:0]);
                    n_pend  = 1'b1;
                    n_cptr  = r_ptr;
                    n_ptr   = w_ptr_inc[CW-1:0];
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count  = r_count - CW'(1);
                        n_elem   = '0;
                        n_last   = 1'b1;
                        n_status = ST_OK;
                        n_state  = S_EMIT;
                    end
                end
            end

            S_ROTRD: begin
                w_raddr = r_head;
                n_state = S_ROTWR;
            end

            S_ROTWR: begin
                // old head value goes to the free tail slot (itself when full)
                w_we     = 1'b1;
                w_waddr  = f_slot(r_head, r_count);
                w_wdata  = w_rdata;
                n_head   = f_slot(r_head, CW'(1));
                n_elem   = '0;
                n_last   = 1'b1;
                n_status = ST_OK;
                n_state  = S_EMIT;
            end

            S_EMIT: begin
                if (i_res_ready) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr   = w_ptr_inc[CW-1:0];
                        n_state = S_READ;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench of the ordered ring list engine.
`timescale 1ns / 1ps
module tb_top;
    import orle_pkg::*;

    localparam int LIST_CAPACITY = 16;
    localparam int CYCLE_LIMIT   = 400_000;
    localparam int DRAIN_CYCLES  = 60;

    // kinds outside the defined set; the block answers them with a plain ok
    localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

    typedef struct {
        logic [ELEM_W-1:0] elem;
        t_status           status;
        logic [CNT_W-1:0]  count;
        logic              last;
    } list_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    orle_in_if  in_ch();
    orle_out_if out_ch();

    ordered_ring_list_engine #(
        .CAPACITY   (LIST_CAPACITY),
        .VALUE_BITS (VAL_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // logical contents, element 0 is the head
    logic [VAL_W-1:0] list_contents[$];
    list_result_t     pending_results[$];
    list_result_t     oldest_result;

    int error_count      = 0;
    int ops_sent         = 0;
    int results_checked  = 0;
    int full_refusals    = 0;
    int delete_misses    = 0;
    int cycle_count      = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Works out the results of one accepted operation and updates the list.
    function automatic void predict_list_op(input logic [KIND_W-1:0] kind,
                                            input logic [VAL_W-1:0] value,
                                            input logic signed [IDX_W-1:0] index);
        list_result_t res;
        int goal;
        int pos;
        res.elem   = '0;
        res.status = ST_OK;
        res.last   = 1'b1;
        case (kind)
            KIND_APPEND: begin
                if (list_contents.size() >= LIST_CAPACITY) begin
                    res.status = ST_FULL;
                    full_refusals++;
                end else begin
                    list_contents.push_back(value);
                end
            end
            KIND_GET: begin
                if (list_contents.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    goal = int'(index);
                    if (goal < 0)
                        goal += list_contents.size();
                    if (goal < 0)
                        goal = 0;
                    goal = goal % list_contents.size();
                    res.elem = list_contents[goal];
                end
            end
            KIND_DELETE: begin
                if (list_contents.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    pos = -1;
                    for (int i = 0; i < list_contents.size(); i++) begin
                        if (pos < 0 && list_contents[i] == value)
                            pos = i;
                    end
                    if (pos < 0) begin
                        res.status = ST_NOTFOUND;
                        delete_misses++;
                    end else begin
                        list_contents.delete(pos);
                    end
                end
            end
            KIND_ROTATE: begin
                if (list_contents.size() == 0)
                    res.status = ST_EMPTY;
                else
                    list_contents.push_back(list_contents.pop_front());
            end
            KIND_READALL: begin
                if (list_contents.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // one result per element from the head, last on the tail
                    for (int i = 0; i < list_contents.size(); i++) begin
                        res.elem  = list_contents[i];
                        res.count = CNT_W'(list_contents.size());
                        res.last  = (i == list_contents.size() - 1);
                        pending_results.push_back(res);
                    end
                    return;
                end
            end
            KIND_CLEAR: list_contents.delete();
            default: ;
        endcase
        res.count = CNT_W'(list_contents.size());
        pending_results.push_back(res);
    endfunction

    // Drives one operation from a falling edge and holds it until the transfer.
    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [VAL_W-1:0] value,
                           input logic signed [IDX_W-1:0] index);
        in_ch.valid <= 1'b1;
        in_ch.kind  <= kind;
        in_ch.value <= value;
        in_ch.index <= index;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        predict_list_op(kind, value, index);
        ops_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            in_ch.valid <= 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    // Receiver: holds one of four ready patterns for a random run, then picks again.
    initial begin : receiver_pattern
        int mode;
        int stall_left;
        int phase;
        out_ch.ready = 1'b0;
        mode = 0;
        stall_left = 0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0) begin
                mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 120);
            end
            stall_left--;
            phase++;
            case (mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 1) == 1);
                2: out_ch.ready <= ((phase % 5) < 2);
                default: out_ch.ready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got elem %h status %0d",
                         $time, out_ch.element, out_ch.status);
                error_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                compare_field("element", oldest_result.elem, out_ch.element);
                compare_field("status", 32'(oldest_result.status), 32'(out_ch.status));
                compare_field("count", 32'(oldest_result.count), 32'(out_ch.count));
                compare_field("last", 32'(oldest_result.last), 32'(out_ch.last));
                results_checked++;
            end
        end
    end

    task automatic test_empty_list_ops();
        send_op(KIND_GET, 32'h0, 5'sd0);
        send_op(KIND_DELETE, 32'h0, 5'sd0);
        send_op(KIND_ROTATE, 32'hFFFF_FFFF, -5'sd1);
        send_op(KIND_READALL, 32'h0, 5'sd0);
        send_op(KIND_CLEAR, 32'h0, 5'sd0);
    endtask

    task automatic test_unused_kinds();
        send_op(KIND_SPARE_6, 32'hFFFF_FFFF, -5'sd1);
        send_op(KIND_SPARE_7, 32'h5555_AAAA, 5'sd15);
    endtask

    // Index below minus the length, negative, and wrapping past the length.
    task automatic test_short_list_get();
        send_op(KIND_APPEND, 32'h0000_0000, 5'sd0);
        send_op(KIND_APPEND, 32'hFFFF_FFFF, -5'sd16);
        send_op(KIND_APPEND, 32'h8000_0001, 5'sd0);
        send_op(KIND_GET, 32'h0, -5'sd16);
        send_op(KIND_GET, 32'h0, -5'sd1);
        send_op(KIND_GET, 32'h0, 5'sd15);
        send_op(KIND_GET, 32'h0, 5'sd0);
    endtask

    task automatic test_rotate_and_delete();
        send_op(KIND_ROTATE, 32'h0, 5'sd0);
        send_op(KIND_DELETE, 32'hFFFF_FFFF, 5'sd0);
        send_op(KIND_DELETE, 32'h0000_1234, 5'sd0);
    endtask

    task automatic test_fill_to_full();
        int k;
        k = 0;
        while (list_contents.size() < LIST_CAPACITY) begin
            send_op(KIND_APPEND, 32'h1 << k, 5'(k));
            k++;
        end
        send_op(KIND_APPEND, 32'hDEAD_BEEF, 5'sd0);
        send_op(KIND_GET, 32'h0, 5'sd15);
        send_op(KIND_GET, 32'h0, -5'sd16);
        send_op(KIND_DELETE, list_contents[LIST_CAPACITY / 2], 5'sd0);
        send_op(KIND_READALL, 32'h0, 5'sd0);
        send_op(KIND_CLEAR, 32'h0, 5'sd0);
    endtask

    // Appends outweigh deletes so the list climbs to full between clears;
    // most deletes aim at a live value, small values make duplicates.
    task automatic test_random_traffic(input int n_ops);
        int sent;
        int burst;
        int sel;
        logic [KIND_W-1:0] kind;
        logic [VAL_W-1:0] value;
        logic signed [IDX_W-1:0] index;
        sent = 0;
        while (sent < n_ops) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < n_ops; b++) begin
                sel   = $urandom_range(0, 99);
                value = $urandom();
                index = IDX_W'($urandom_range(0, 31));
                if (sel < 45) begin
                    kind = KIND_APPEND;
                    if ($urandom_range(0, 3) == 0)
                        value = $urandom_range(0, 7);
                end else if (sel < 62) begin
                    kind = KIND_GET;
                end else if (sel < 78) begin
                    kind = KIND_DELETE;
                    if (list_contents.size() != 0 && $urandom_range(0, 3) != 0)
                        value = list_contents[$urandom_range(0, list_contents.size() - 1)];
                end else if (sel < 87) begin
                    kind = KIND_ROTATE;
                end else if (sel < 95) begin
                    kind = KIND_READALL;
                end else if (sel < 97) begin
                    kind = KIND_CLEAR;
                end else begin
                    kind = ($urandom_range(0, 1) == 1) ? KIND_SPARE_7 : KIND_SPARE_6;
                end
                send_op(kind, value, index);
                sent++;
            end
            // about a quarter of the bursts run straight into the next one
            if ($urandom_range(0, 3) != 0)
                idle_gap($urandom_range(1, 6));
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.kind  = KIND_APPEND;
        in_ch.value = '0;
        in_ch.index = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list_ops();
        test_unused_kinds();
        idle_gap($urandom_range(1, 4));
        test_short_list_get();
        test_rotate_and_delete();
        idle_gap($urandom_range(1, 4));
        test_fill_to_full();
        idle_gap($urandom_range(1, 4));
        test_random_traffic(220);
        idle_gap(1);

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d list operations, %0d results compared.", ops_sent, results_checked);
        $display("Appends refused on a full list: %0d, deletes with no match: %0d.",
                 full_refusals, delete_misses);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
